// ===== src/afrm_pkg.sv =====
`timescale 1ns / 1ps

package afrm_pkg;

  localparam int HW_SLOTS = 8;
  localparam int CH_W = 4;
  localparam int VAL_W = 16;
  localparam int SUM_W = 22;
  localparam int CNT_W = 10;
  localparam int AVG_W = 12;
  localparam int IDX_W = 3;
  localparam int CFG_W = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  localparam int COUNT_HW_MAX = 1023;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_END_FRAME = 1'b1;

  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_CHANNEL_MAP = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_ABORTED = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [CH_W-1:0]  sample_channel;
    logic [VAL_W-1:0] sample_value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] slot_index;
    logic [AVG_W-1:0] average;
    logic             has_data;
    logic             status;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [AVG_W-1:0] avg;
  } entry_t;

endpackage

// ===== src/afrm_ram.sv =====
`timescale 1ns / 1ps

module afrm_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/afrm_div.sv =====
`timescale 1ns / 1ps

module afrm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [afrm_pkg::SUM_W-1:0] dividend,
  input  logic [afrm_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [afrm_pkg::SUM_W-1:0] quotient
);

  localparam int STEPS = afrm_pkg::SUM_W;
  localparam int STEP_W = $clog2(STEPS);

  logic                       busy;
  logic [STEP_W-1:0]          step;
  logic [afrm_pkg::CNT_W-1:0] rem;
  logic [afrm_pkg::CNT_W-1:0] dvs;
  logic [afrm_pkg::SUM_W-1:0] quo;

  logic [afrm_pkg::CNT_W:0]   rem_sh;
  logic [afrm_pkg::CNT_W:0]   diff;
  logic                       qbit;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem, quo[afrm_pkg::SUM_W-1]};
    diff = rem_sh - {1'b0, dvs};
    qbit = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= qbit ? diff[afrm_pkg::CNT_W-1:0] : rem_sh[afrm_pkg::CNT_W-1:0];
      quo <= {quo[afrm_pkg::SUM_W-2:0], qbit};
    end
  end

  assign quotient = quo;

endmodule

// ===== src/adc_channel_frame_averager_unit.sv =====
`timescale 1ns / 1ps

// Per-channel frame averager. For a converter sample item, the slot's
// accumulator entry is read from the slot RAM, then the updated sum and count
// are written back while the count is below its limit. For an end-of-frame
// item, each active slot in turn is read; the bit-serial divider gives sum /
// count for a slot that saw a sample, a slot that saw none keeps its previous
// average, and the result is emitted as the sum and count clear. An aborted
// frame gives one abort result and a frame with no active slot gives none. No
// new item is taken until the current one is done; a finished result waits in
// the output register, so the block keeps taking samples while it is stalled.
// Accumulators and previous averages clear at reset through per-slot valid
// bits, with no clearing pass.
module adc_channel_frame_averager_unit #(
  parameter int SLOTS = 8,
  parameter int CHANNELS = 10,
  parameter int SAMPLE_BITS = 12,
  parameter int MAX_FRAME_SAMPLES = 1023
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  afrm_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output afrm_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [afrm_pkg::CFG_W-1:0] cfg_data
);

  localparam int NSLOT = (SLOTS < afrm_pkg::HW_SLOTS) ? SLOTS : afrm_pkg::HW_SLOTS;
  localparam int SW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int CNT_LIM_I = (MAX_FRAME_SAMPLES < afrm_pkg::COUNT_HW_MAX) ?
                             MAX_FRAME_SAMPLES : afrm_pkg::COUNT_HW_MAX;
  localparam logic [afrm_pkg::CNT_W-1:0] CNT_LIM = afrm_pkg::CNT_W'(CNT_LIM_I);
  localparam int ENTRY_W = $bits(afrm_pkg::entry_t);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_ACC  = 7'b0000010,
    ST_RD   = 7'b0000100,
    ST_DAT  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_EMIT = 7'b0100000,
    ST_ERR  = 7'b1000000
  } state_t;

  state_t state;

  logic [3:0]                 slot_count;
  logic [afrm_pkg::CFG_W-1:0] slot_map;
  logic                       aborted;
  logic [NSLOT-1:0]           frm_ok;
  logic [NSLOT-1:0]           avg_ok;
  logic [SW-1:0]              slot;
  logic [3:0]                 n_q;
  logic [SAMPLE_BITS-1:0]     val;
  logic [afrm_pkg::AVG_W-1:0] avg_q;
  logic                       has_q;

  logic [3:0]                 n_act;
  logic                       hit;
  logic [SW-1:0]              hit_slot;
  logic                       ch_bad;
  logic [SAMPLE_BITS-1:0]     val_eff;
  logic                       req_take;
  logic                       rsp_free;
  logic                       rsp_load;
  logic                       is_last;

  logic                       ram_we;
  logic [SW-1:0]              ram_raddr;
  afrm_pkg::entry_t           ram_wdata;
  afrm_pkg::entry_t           ram_rdata;
  logic [ENTRY_W-1:0]         ram_rdata_raw;

  logic [afrm_pkg::SUM_W-1:0] sum_eff;
  logic [afrm_pkg::CNT_W-1:0] cnt_eff;
  logic [afrm_pkg::AVG_W-1:0] avg_eff;
  logic [afrm_pkg::SUM_W:0]   sum_add;
  logic [afrm_pkg::SUM_W-1:0] sum_new;

  logic                       div_start;
  logic                       div_done;
  logic [afrm_pkg::SUM_W-1:0] div_quo;
  logic [afrm_pkg::AVG_W-1:0] div_avg;

  assign req_stall = (state != ST_IDLE);
  assign req_take = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign rsp_load = ((state == ST_EMIT) || (state == ST_ERR)) && rsp_free;
  assign n_act = (slot_count > 4'(NSLOT)) ? 4'(NSLOT) : slot_count;
  assign is_last = ((4'(slot) + 4'd1) == n_q);

  // first active slot mapped to the sample's channel
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    for (int j = NSLOT - 1; j >= 0; j--) begin
      if ((4'(j) < n_act) && (slot_map[4*j +: 4] == req.sample_channel)) begin
        hit = 1'b1;
        hit_slot = SW'(j);
      end
    end
  end

  assign ch_bad = ({1'b0, req.sample_channel} >= 5'(CHANNELS));
  assign val_eff = ((req.sample_value >> SAMPLE_BITS) != '0) ? '0 :
                   req.sample_value[SAMPLE_BITS-1:0];

  assign ram_rdata = afrm_pkg::entry_t'(ram_rdata_raw);
  assign sum_eff = frm_ok[slot] ? ram_rdata.sum : '0;
  assign cnt_eff = frm_ok[slot] ? ram_rdata.cnt : '0;
  assign avg_eff = avg_ok[slot] ? ram_rdata.avg : '0;
  assign sum_add = {1'b0, sum_eff} + (afrm_pkg::SUM_W + 1)'(val);
  assign sum_new = sum_add[afrm_pkg::SUM_W] ? afrm_pkg::SUM_MAX :
                   sum_add[afrm_pkg::SUM_W-1:0];
  assign div_avg = (div_quo > afrm_pkg::SUM_W'(afrm_pkg::AVG_MAX)) ? afrm_pkg::AVG_MAX :
                   div_quo[afrm_pkg::AVG_W-1:0];

  assign ram_raddr = (state == ST_IDLE) ? hit_slot : slot;
  assign div_start = (state == ST_DAT) && (cnt_eff != '0);

  always_comb begin
    ram_we = 1'b0;
    ram_wdata.sum = sum_new;
    ram_wdata.cnt = cnt_eff + 1'b1;
    ram_wdata.avg = avg_eff;
    unique case (state)
      ST_ACC: begin
        ram_we = (cnt_eff < CNT_LIM);
      end
      ST_EMIT: begin
        ram_we = rsp_free;
        ram_wdata.sum = '0;
        ram_wdata.cnt = '0;
        ram_wdata.avg = avg_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  afrm_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NSLOT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

  afrm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_eff),
    .divisor (cnt_eff),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= 4'd1;
      slot_map <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afrm_pkg::REG_SLOT_COUNT:  slot_count <= cfg_data[3:0];
        afrm_pkg::REG_CHANNEL_MAP: slot_map <= cfg_data;
        default:                   slot_map <= slot_map;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      aborted <= 1'b0;
      frm_ok <= '0;
      avg_ok <= '0;
      slot <= '0;
      n_q <= '0;
    end else begin
      if (ram_we) begin
        avg_ok[slot] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            if (req.cmd == afrm_pkg::CMD_END_FRAME) begin
              n_q <= n_act;
              slot <= '0;
              if (aborted) begin
                state <= ST_ERR;
              end else if (n_act == 4'd0) begin
                frm_ok <= '0;
              end else begin
                state <= ST_RD;
              end
            end else if (!aborted) begin
              if (ch_bad) begin
                aborted <= 1'b1;
              end else if (hit) begin
                slot <= hit_slot;
                state <= ST_ACC;
              end
            end
          end
        end
        ST_ACC: begin
          if (ram_we) begin
            frm_ok[slot] <= 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_RD: begin
          state <= ST_DAT;
        end
        ST_DAT: begin
          state <= (cnt_eff != '0) ? ST_DIV : ST_EMIT;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (rsp_free) begin
            if (is_last) begin
              frm_ok <= '0;
              state <= ST_IDLE;
            end else begin
              slot <= slot + 1'b1;
              state <= ST_RD;
            end
          end
        end
        ST_ERR: begin
          if (rsp_free) begin
            frm_ok <= '0;
            aborted <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      val <= val_eff;
    end
    if (state == ST_DAT) begin
      avg_q <= avg_eff;
      has_q <= (cnt_eff != '0);
    end else if ((state == ST_DIV) && div_done) begin
      avg_q <= div_avg;
    end
    if ((state == ST_EMIT) && rsp_free) begin
      rsp.slot_index <= afrm_pkg::IDX_W'(slot);
      rsp.average <= avg_q;
      rsp.has_data <= has_q;
      rsp.status <= afrm_pkg::STATUS_OK;
      rsp.last <= is_last;
    end else if ((state == ST_ERR) && rsp_free) begin
      rsp.slot_index <= '0;
      rsp.average <= '0;
      rsp.has_data <= 1'b0;
      rsp.status <= afrm_pkg::STATUS_ABORTED;
      rsp.last <= 1'b1;
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_abort_rsp_form: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == afrm_pkg::STATUS_ABORTED)) |->
      (rsp.last && !rsp.has_data))
    else $error("abort item not final or carries data");

  a_acc_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |=> (state == ST_IDLE))
    else $error("accumulate did not return to idle");

  a_ram_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == ST_ACC) || (state == ST_EMIT)))
    else $error("slot ram written outside accumulate or emit");

endmodule
